FILE: rtl/issep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// issep_pkg
// Shared sizes, codes and the request/response bundles between the scanner
// front end and the indent stack unit.
// ----------------------------------------------------------------------------
package issep_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int INDENT_BITS = 16;
  localparam int CHAR_W      = 21;
  localparam int TAB_W       = 4;

  localparam logic [TAB_W-1:0] TAB_RESET = 4'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_LINE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_BLOCK = 2'd1,
    OP_LINE  = 2'd2
  } op_t;

  typedef struct packed {
    logic                   start;
    op_t                    op;
    logic [INDENT_BITS-1:0] indent;
    logic                   ack;
  } stk_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    kind_t            kind;
    logic [CNT_W-1:0] depth;
  } stk_rsp_t;

endpackage

FILE: rtl/issep_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// issep_stack
// Indent stack with a small sequencer around one shared indent comparator.
// Decides the separator token at scan end and updates the stack.
// ----------------------------------------------------------------------------
module issep_stack (
  input  logic               clk,
  input  logic               rst,
  input  issep_pkg::stk_req_t req,
  output issep_pkg::stk_rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } stk_state_t;

  stk_state_t state, state_next;

  logic [issep_pkg::INDENT_BITS-1:0] mem [issep_pkg::STACK_DEPTH];
  logic [issep_pkg::INDENT_BITS-1:0] rd_data;

  logic [issep_pkg::CNT_W-1:0]       count, count_next;
  logic [issep_pkg::INDENT_BITS-1:0] ind, ind_next;
  issep_pkg::op_t                    op, op_next;
  issep_pkg::kind_t                  kind, kind_next;

  logic                              we;
  logic [issep_pkg::PTR_W-1:0]       waddr;
  logic [issep_pkg::PTR_W-1:0]       top_ptr;
  logic                              gt, lt, eq;
  logic                              full;

  assign top_ptr = issep_pkg::PTR_W'(count - issep_pkg::CNT_W'(1));
  assign full    = (count == issep_pkg::CNT_W'(issep_pkg::STACK_DEPTH));

  // shared comparator: scan indent against the stack top
  assign gt = (ind > rd_data);
  assign lt = (ind < rd_data);
  assign eq = (ind == rd_data);

  always_comb begin
    state_next = state;
    count_next = count;
    ind_next   = ind;
    op_next    = op;
    kind_next  = kind;
    we         = 1'b0;
    waddr      = top_ptr;
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          ind_next = req.indent;
          op_next  = req.op;
          unique case (req.op)
            issep_pkg::OP_BLOCK: begin
              if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                count_next = issep_pkg::CNT_W'(1);
                kind_next  = issep_pkg::KIND_BLOCK;
                state_next = S_DONE;
              end else begin
                state_next = S_RD;
              end
            end
            issep_pkg::OP_LINE: begin
              if (count == '0) begin
                kind_next  = issep_pkg::KIND_LINE;
                state_next = S_DONE;
              end else begin
                state_next = S_RD;
              end
            end
            default: begin
              kind_next  = issep_pkg::KIND_NONE;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (op == issep_pkg::OP_BLOCK) begin
          // push a deeper level, else overwrite the top
          we = 1'b1;
          if (gt && !full) begin
            waddr      = count[issep_pkg::PTR_W-1:0];
            count_next = count + issep_pkg::CNT_W'(1);
          end
          kind_next  = issep_pkg::KIND_BLOCK;
          state_next = S_DONE;
        end else if (lt) begin
          // pop one level; look again while the stack is not empty
          count_next = count - issep_pkg::CNT_W'(1);
          if (count == issep_pkg::CNT_W'(1)) begin
            kind_next  = issep_pkg::KIND_LINE;
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end else begin
          kind_next  = eq ? issep_pkg::KIND_LINE : issep_pkg::KIND_NONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (req.ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ind  <= ind_next;
    op   <= op_next;
    kind <= kind_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= ind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_data <= mem[top_ptr];
    end
  end

  assign rsp.busy  = (state != S_IDLE);
  assign rsp.done  = (state == S_DONE);
  assign rsp.kind  = kind;
  assign rsp.depth = count;

endmodule

FILE: rtl/indent_stack_separator_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_stack_separator_scanner
// Offside-rule scanner: counts indentation after a newline and decides a
// block or line separator against an indent stack.
// ----------------------------------------------------------------------------
// A character that does not end a scan (newline, indent space or tab, or a
// character outside a scan) does not engage the stack unit. A character that
// ends a scan, or a scan start with neither separator allowed, yields one
// result beat. The stack unit goes straight to done when the stack is not
// consulted or is empty; else a block separator takes one read of the stack
// memory and one pass through the shared indent comparator, and a line
// separator one such read and pass per level popped, plus a final one unless
// the pops empty the stack. in_stall stays high while the stack unit works
// and until the result is in the output register. tab_width is to be written
// by the user with cfg_write/cfg_data while the block is idle (not enforced).
module indent_stack_separator_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] character,
  input  logic        scan_start,
  input  logic        block_sep_allowed,
  input  logic        line_sep_allowed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  token_kind,
  output logic [15:0] measured_indent,
  output logic [6:0]  stack_depth
);

  localparam logic [issep_pkg::CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [issep_pkg::CHAR_W-1:0] CH_LF    = 21'h0A;
  localparam logic [issep_pkg::CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [issep_pkg::CHAR_W-1:0] CH_SPACE = 21'h20;

  function automatic logic is_cont(input logic [issep_pkg::CHAR_W-1:0] c);
    logic r;
    r = (c == 21'h2E) || (c == 21'h21) || (c == 21'h3D) || (c == 21'h3C) ||
        (c == 21'h3E) || (c == 21'h7C) || (c == 21'h26) || (c == 21'h2B) ||
        (c == 21'h2A) || (c == 21'h3F);
    return r;
  endfunction

  logic [issep_pkg::TAB_W-1:0]       tab_width;
  logic [issep_pkg::INDENT_BITS-1:0] acc, acc_next, acc_base;
  logic                              nl, nl_next, nl_base;
  logic                              active, active_next;
  logic [1:0]                        allowed, allowed_next, allowed_eff;

  issep_pkg::stk_req_t req;
  issep_pkg::stk_rsp_t rsp;

  logic in_fire;
  logic is_nl, is_ws;
  logic ack;

  assign in_stall = rsp.busy;
  assign in_fire  = in_valid && !in_stall;
  assign ack      = !out_valid || !out_stall;

  assign is_nl = (character == CH_CR) || (character == CH_LF);
  assign is_ws = (character == CH_SPACE) || (character == CH_TAB);

  assign allowed_eff = scan_start ? {line_sep_allowed, block_sep_allowed} : allowed;
  assign nl_base     = scan_start ? 1'b0 : nl;
  assign acc_base    = scan_start ? '0 : acc;

  always_comb begin
    acc_next     = acc;
    nl_next      = nl;
    active_next  = active;
    allowed_next = allowed;
    req.start    = 1'b0;
    req.op       = issep_pkg::OP_NOP;
    req.indent   = acc_base;
    req.ack      = ack;
    if (in_fire && (scan_start || active)) begin
      acc_next     = acc_base;
      nl_next      = nl_base;
      allowed_next = allowed_eff;
      active_next  = 1'b1;
      if (scan_start && (allowed_eff == 2'b00)) begin
        // nothing allowed: report at once, no scan opens
        active_next = 1'b0;
        req.start   = 1'b1;
      end else if (is_nl) begin
        nl_next  = 1'b1;
        acc_next = '0;
      end else if (is_ws && nl_base) begin
        acc_next = acc_base + ((character == CH_TAB) ?
                   issep_pkg::INDENT_BITS'(tab_width) : issep_pkg::INDENT_BITS'(1));
      end else begin
        // end of scan; the character is not consumed
        active_next = 1'b0;
        req.start   = 1'b1;
        if (!nl_base || is_cont(character)) begin
          req.op = issep_pkg::OP_NOP;
        end else if (allowed_eff[0]) begin
          req.op = issep_pkg::OP_BLOCK;
        end else begin
          req.op = issep_pkg::OP_LINE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= issep_pkg::TAB_RESET;
      acc       <= '0;
      nl        <= 1'b0;
      active    <= 1'b0;
      allowed   <= 2'b00;
    end else begin
      if (cfg_write) begin
        tab_width <= cfg_data;
      end
      acc     <= acc_next;
      nl      <= nl_next;
      active  <= active_next;
      allowed <= allowed_next;
    end
  end

  issep_stack u_stack (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // output register: load when the stack unit finishes and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.done && ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done && ack) begin
      token_kind      <= rsp.kind;
      measured_indent <= 16'(acc);
      stack_depth     <= 7'(rsp.depth);
    end
  end

endmodule

FILE: rtl/issep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// issep_checker
// Port-level checks on the separator scanner, bound to the top level.
// ----------------------------------------------------------------------------
module issep_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        scan_start,
  input logic        block_sep_allowed,
  input logic        line_sep_allowed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  token_kind,
  input logic [15:0] measured_indent,
  input logic [6:0]  stack_depth
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
    $stable(measured_indent) && $stable(stack_depth))
    else $error("stalled result beat changed");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stack_depth <= 7'(issep_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_block_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == issep_pkg::KIND_BLOCK) |-> stack_depth != 7'd0)
    else $error("block separator with empty stack");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind == issep_pkg::KIND_NONE) ||
                  (token_kind == issep_pkg::KIND_BLOCK) ||
                  (token_kind == issep_pkg::KIND_LINE))
    else $error("undefined token kind");

  // a start with nothing allowed always produces a result, so input stalls
  a_none_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && scan_start && !block_sep_allowed && !line_sep_allowed
    |=> in_stall)
    else $error("no-separator start did not enter result path");

endmodule

bind indent_stack_separator_scanner issep_checker u_issep_checker (.*);
